### rtl/prqs_pkg.sv
// Shared types, operation codes and constants for the priority ready-queue scheduler.
package prqs_pkg;

   localparam int ID_W        = 8;
   localparam int PRI_W       = 6;
   localparam int SLICE_W     = 8;
   localparam int OP_W        = 3;
   localparam int RCOUNT_W    = 5;
   localparam int PRI_MAX     = (1 << PRI_W) - 1;

   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int MAX_PRIORITY_DEF = 63;
   localparam int FIFO_DEPTH       = 2;

   localparam logic [SLICE_W-1:0] SLICE_LIMIT_RST = 8'd4;
   localparam logic [ID_W-1:0]    INIT_ID         = 8'd1;
   localparam logic [ID_W-1:0]    FIRST_NEW_ID    = 8'd2;
   localparam int                 INIT_PRI        = 31;

   localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd0;
   localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
   localparam logic [OP_W-1:0] OP_YIELD   = 3'd2;
   localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;
   localparam logic [OP_W-1:0] OP_SETPRI  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  thread_id;
      logic [PRI_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     running_id;
      logic [PRI_W-1:0]    running_priority;
      logic                running_idle;
      logic                switched;
      logic [ID_W-1:0]     assigned_id;
      logic                queue_full_error;
      logic [RCOUNT_W-1:0] ready_count;
   } rsp_type;

   // command as handed from the front end to the back end, priority already clamped
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  thread_id;
      logic [PRI_W-1:0] priority_val;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

### rtl/prqs_cmd_fifo.sv
// Two-entry command queue between the scheduler front end and back end.
module prqs_cmd_fifo
   import prqs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_cmd,
   input  logic            pop,
   output cmd_type         pop_cmd,
   output fifo_status_type status
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/prqs_front.sv
// Front end: takes requests, clamps the priority and forwards commands to the queue.
module prqs_front
   import prqs_pkg::*;
#(
   parameter int MAX_PRIORITY = MAX_PRIORITY_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_item,
   input  fifo_status_type fifo_status,
   output logic            push,
   output cmd_type         push_cmd
);

   localparam int               MAX_CLIP = (MAX_PRIORITY > PRI_MAX) ? PRI_MAX : MAX_PRIORITY;
   localparam logic [PRI_W-1:0] MAX_P    = PRI_W'(MAX_CLIP);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_ff, stage_in;
   logic    accept;

   assign busy     = stage_valid_ff;
   assign accept   = start && !stage_valid_ff;
   assign push     = stage_valid_ff && !fifo_status.full;
   assign push_cmd = stage_ff;

   always_comb begin
      stage_in              = stage_ff;
      stage_in.op           = req_item.op;
      stage_in.thread_id    = req_item.thread_id;
      stage_in.priority_val = (req_item.priority_req > MAX_P) ? MAX_P : req_item.priority_req;
      stage_valid_in        = stage_valid_ff;
      if (push) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

endmodule

### rtl/prqs_back.sv
// Back end: ordered ready queue, running-thread state and the operation sequencer.
module prqs_back
   import prqs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int MAX_PRIORITY = MAX_PRIORITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   input  logic [SLICE_W-1:0] slice_limit,
   output logic               rsp_strobe,
   output rsp_type            rsp_item
);

   localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int RST_PRI  = (INIT_PRI > MAX_PRIORITY) ? MAX_PRIORITY : INIT_PRI;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_YIELD  = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DISP   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   localparam logic [1:0] AFT_NONE  = 2'd0;
   localparam logic [1:0] AFT_YIELD = 2'd1;
   localparam logic [1:0] AFT_DISP  = 2'd2;

   logic [ID_W-1:0]    q_id_ff  [QUEUE_DEPTH];
   logic [ID_W-1:0]    q_id_in  [QUEUE_DEPTH];
   logic [PRI_W-1:0]   q_pri_ff [QUEUE_DEPTH];
   logic [PRI_W-1:0]   q_pri_in [QUEUE_DEPTH];

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [ID_W-1:0]    ins_id_ff, ins_id_in;
   logic [PRI_W-1:0]   ins_pri_ff, ins_pri_in;
   logic [1:0]         after_ff, after_in;
   logic [ID_W-1:0]    cur_id_ff, cur_id_in;
   logic [PRI_W-1:0]   cur_pri_ff, cur_pri_in;
   logic               cur_idle_ff, cur_idle_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [ID_W-1:0]    assigned_ff, assigned_in;
   logic               switched_ff, switched_in;
   logic               error_ff, error_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               q_full;
   logic [PRI_W-1:0]   run_pri;
   logic [SLICE_W-1:0] slice_next;
   logic [CNT_W+4:0]   count_ext;

   assign q_full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign run_pri    = cur_idle_ff ? '0 : cur_pri_ff;
   assign slice_next = (slice_ff == '1) ? slice_ff : slice_ff + 1'b1;
   assign count_ext  = {5'd0, count_ff};
   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      ins_id_in    = ins_id_ff;
      ins_pri_in   = ins_pri_ff;
      after_in     = after_ff;
      cur_id_in    = cur_id_ff;
      cur_pri_in   = cur_pri_ff;
      cur_idle_in  = cur_idle_ff;
      slice_in     = slice_ff;
      next_id_in   = next_id_ff;
      assigned_in  = assigned_ff;
      switched_in  = switched_ff;
      error_in     = error_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_id_in[i]  = q_id_ff[i];
         q_pri_in[i] = q_pri_ff[i];
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               switched_in = 1'b0;
               error_in    = 1'b0;
               assigned_in = '0;
               pos_in      = '0;
               case (cmd.op)
                  OP_UNBLOCK: begin
                     if (q_full) begin
                        error_in = 1'b1;
                        state_in = S_RESP;
                     end else begin
                        ins_id_in  = cmd.thread_id;
                        ins_pri_in = cmd.priority_val;
                        after_in   = AFT_NONE;
                        state_in   = S_SEARCH;
                     end
                  end
                  OP_CREATE: begin
                     // the id is used up even when the insert is dropped
                     assigned_in = next_id_ff;
                     next_id_in  = next_id_ff + 1'b1;
                     if (q_full) begin
                        error_in = 1'b1;
                        state_in = S_RESP;
                     end else begin
                        ins_id_in  = next_id_ff;
                        ins_pri_in = cmd.priority_val;
                        after_in   = (cmd.priority_val > run_pri) ? AFT_YIELD : AFT_NONE;
                        state_in   = S_SEARCH;
                     end
                  end
                  OP_YIELD: begin
                     state_in = S_YIELD;
                  end
                  OP_BLOCK: begin
                     state_in = S_DISP;
                  end
                  OP_TICK: begin
                     slice_in = slice_next;
                     state_in = (slice_next >= slice_limit) ? S_YIELD : S_RESP;
                  end
                  OP_SETPRI: begin
                     state_in = S_RESP;
                     if (!cur_idle_ff) begin
                        cur_pri_in = cmd.priority_val;
                        if ((count_ff != '0) && (q_pri_ff[0] > cmd.priority_val)) begin
                           state_in = S_YIELD;
                        end
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_YIELD: begin
            // idle is never requeued; a full queue keeps the running thread
            if (cur_idle_ff) begin
               state_in = S_DISP;
            end else if (q_full) begin
               error_in = 1'b1;
               state_in = S_RESP;
            end else begin
               ins_id_in  = cur_id_ff;
               ins_pri_in = cur_pri_ff;
               after_in   = AFT_DISP;
               pos_in     = '0;
               state_in   = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // walk past entries of equal or higher priority, one per cycle
            if ((pos_ff < count_ff) && (ins_pri_ff <= q_pri_ff[pos_ff[IDX_W-1:0]])) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (CNT_W'(i) == pos_ff) begin
                  q_id_in[i]  = ins_id_ff;
                  q_pri_in[i] = ins_pri_ff;
               end else if ((CNT_W'(i) > pos_ff) && (CNT_W'(i) <= count_ff)) begin
                  q_id_in[i]  = q_id_ff[(i == 0) ? 0 : i - 1];
                  q_pri_in[i] = q_pri_ff[(i == 0) ? 0 : i - 1];
               end
            end
            count_in = count_ff + 1'b1;
            case (after_ff)
               AFT_YIELD: state_in = S_YIELD;
               AFT_DISP:  state_in = S_DISP;
               default:   state_in = S_RESP;
            endcase
         end
         S_DISP: begin
            if (count_ff != '0) begin
               cur_id_in   = q_id_ff[0];
               cur_pri_in  = q_pri_ff[0];
               cur_idle_in = 1'b0;
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  q_id_in[i]  = q_id_ff[(i == QUEUE_DEPTH - 1) ? i : i + 1];
                  q_pri_in[i] = q_pri_ff[(i == QUEUE_DEPTH - 1) ? i : i + 1];
               end
               count_in = count_ff - 1'b1;
            end else begin
               cur_id_in   = '0;
               cur_pri_in  = '0;
               cur_idle_in = 1'b1;
            end
            slice_in    = '0;
            switched_in = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in            = 1'b1;
            rsp_in.running_id       = cur_id_ff;
            rsp_in.running_priority = cur_pri_ff;
            rsp_in.running_idle     = cur_idle_ff;
            rsp_in.switched         = switched_ff;
            rsp_in.assigned_id      = assigned_ff;
            rsp_in.queue_full_error = error_ff;
            rsp_in.ready_count      = count_ext[RCOUNT_W-1:0];
            state_in                = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_id_ff[i]  <= q_id_in[i];
         q_pri_ff[i] <= q_pri_in[i];
      end
      pos_ff      <= pos_in;
      ins_id_ff   <= ins_id_in;
      ins_pri_ff  <= ins_pri_in;
      after_ff    <= after_in;
      assigned_ff <= assigned_in;
      switched_ff <= switched_in;
      error_ff    <= error_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_id_ff    <= INIT_ID;
         cur_pri_ff   <= PRI_W'(RST_PRI);
         cur_idle_ff  <= 1'b0;
         slice_ff     <= '0;
         next_id_ff   <= FIRST_NEW_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_id_ff    <= cur_id_in;
         cur_pri_ff   <= cur_pri_in;
         cur_idle_ff  <= cur_idle_in;
         slice_ff     <= slice_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("ready queue count beyond depth");

   a_search_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (pos_ff <= count_ff))
      else $error("insert position past end of queue");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.running_idle) |->
         ((rsp_item.running_id == '0) && (rsp_item.running_priority == '0)))
      else $error("idle thread reported with non-zero id or priority");

   a_error_no_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.queue_full_error) |-> !rsp_item.switched)
      else $error("dispatch reported on a dropped insert");

   a_shift_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> !q_full)
      else $error("insert into a full queue");

endmodule

### rtl/priority_ready_queue_scheduler.sv
// Path: an accepted item passes the front-end stage register and the 2-entry command queue
// to the back-end sequencer (IDLE, any YIELD, SEARCH, SHIFT, DISP, then RESP); each ordered
// insert walks queued entries in SEARCH, so a preempting create (two inserts) is longest.
// Flow: the front end holds one item and takes another only once it is pushed to the queue;
// sustained rate is the back end's service time. Results cannot be stalled.
// Reset: synchronous, clears control state; queue contents stay undefined, no clearing pass.
module priority_ready_queue_scheduler
   import prqs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int MAX_PRIORITY = MAX_PRIORITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_strobe,
   output rsp_type            rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SLICE_W-1:0] csr_data
);

   logic [SLICE_W-1:0] slice_limit_ff, slice_limit_in;
   fifo_status_type    fifo_status;
   logic               push, pop;
   cmd_type            push_cmd, pop_cmd;

   assign csr_ready      = 1'b1;
   assign slice_limit_in = (csr_valid && csr_ready) ? csr_data : slice_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_limit_ff <= SLICE_LIMIT_RST;
      end else begin
         slice_limit_ff <= slice_limit_in;
      end
   end

   prqs_front #(
      .MAX_PRIORITY (MAX_PRIORITY)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .fifo_status (fifo_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   prqs_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (fifo_status)
   );

   prqs_back #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAX_PRIORITY (MAX_PRIORITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!fifo_status.empty),
      .cmd         (pop_cmd),
      .cmd_pop     (pop),
      .slice_limit (slice_limit_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule
